### rtl/sobel_edge_magnitude_rgb_macros.svh
// assertion macros for the sobel edge magnitude block
`ifndef SOBEL_EDGE_MAGNITUDE_RGB_MACROS_SVH
`define SOBEL_EDGE_MAGNITUDE_RGB_MACROS_SVH
// implication checked on every rising clock edge outside reset
`define SEM_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);
// next-cycle implication
`define SEM_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);
`endif

### rtl/sem_pkg.sv
// shared types and constants for the sobel edge magnitude block
package sem_pkg;
    localparam int MAX_WIDTH = 1024;
    localparam int COL_W = $clog2(MAX_WIDTH);
    localparam int ROW_W = 12;
    localparam int HEIGHT_LIMIT = 4096;
    localparam int CFG_DATA_W = 13;
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] REG_WIDTH = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 1'b1;
    localparam logic CMD_PIXEL = 1'b0;
    localparam logic CMD_FLUSH = 1'b1;
    localparam logic [19:0] SAT_BOUND = 20'd65280;

    typedef struct packed {
        logic       command;
        logic [7:0] in_red;
        logic [7:0] in_green;
        logic [7:0] in_blue;
    } sem_in_t;

    typedef struct packed {
        logic [7:0] out_red;
        logic [7:0] out_green;
        logic [7:0] out_blue;
        logic       frame_end;
    } sem_out_t;

    typedef enum logic [2:0] {
        ST_IDLE, ST_READ, ST_WIN, ST_GRAD, ST_SQR, ST_ROOT, ST_OUT
    } sem_state_t;

    typedef struct packed {
        logic load;
        logic read;
        logic shift;
        logic grad;
        logic square;
        logic root_start;
        logic root_step;
        logic publish;
    } sem_cmd_t;

    typedef struct packed {
        logic skip;
        logic emit;
        logic root_done;
    } sem_stat_t;
endpackage

### rtl/sem_ctrl.sv
// controller state machine that sequences one request through the datapath
module sem_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic              out_busy,
    input  sem_pkg::sem_stat_t stat,
    output sem_pkg::sem_cmd_t  cmd
);
    import sem_pkg::*;

    sem_state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) state_reg <= ST_IDLE;
        else state_reg <= state_next;
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: if (s_valid) state_next = ST_READ;
            ST_READ: state_next = stat.skip ? ST_IDLE : ST_WIN;
            ST_WIN:  state_next = stat.emit ? ST_GRAD : ST_IDLE;
            ST_GRAD: state_next = ST_SQR;
            ST_SQR:  state_next = ST_ROOT;
            ST_ROOT: if (stat.root_done) state_next = ST_OUT;
            ST_OUT:  if (!out_busy) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        cmd = '0;
        s_ready = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                cmd.load = s_valid;
            end
            ST_READ: cmd.read = 1'b1;
            ST_WIN:  cmd.shift = 1'b1;
            ST_GRAD: cmd.grad = 1'b1;
            ST_SQR: begin
                cmd.square = 1'b1;
                cmd.root_start = 1'b1;
            end
            ST_ROOT: cmd.root_step = 1'b1;
            ST_OUT:  cmd.publish = !out_busy;
            default: cmd = '0;
        endcase
    end

`include "sobel_edge_magnitude_rgb_macros.svh"
    `SEM_ASSERT_IMP(a_ready_idle, s_ready, state_reg == ST_IDLE, "ready outside idle")
    `SEM_ASSERT_NEXT(a_load_read, cmd.load, state_reg == ST_READ, "load not followed by read")
    `SEM_ASSERT_IMP(a_pub_free, cmd.publish, !out_busy, "publish over a waiting result")
endmodule

### rtl/sem_datapath.sv
// line stores, window, position counters, gradient and rounded root per channel
module sem_datapath (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  sem_pkg::sem_in_t                s_data,
    input  logic                            cfg_we,
    input  logic [sem_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [sem_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  sem_pkg::sem_cmd_t               cmd,
    output sem_pkg::sem_stat_t              stat,
    output logic                            out_busy,
    input  logic                            m_ready,
    output logic                            m_valid,
    output sem_pkg::sem_out_t               m_data
);
    import sem_pkg::*;

    logic [10:0] width_cfg_reg;
    logic [12:0] height_cfg_reg;
    logic [COL_W:0] w_eff;
    logic [ROW_W:0] h_eff;
    logic [COL_W-1:0] in_col_reg, out_col_reg;
    logic [ROW_W:0] in_row_reg;
    logic [ROW_W-1:0] out_row_reg;
    sem_in_t req_reg;
    logic [23:0] ram [0:2*MAX_WIDTH-1];
    logic [23:0] top_q, mid_q;
    logic [23:0] win_reg [0:2][0:2];
    logic real_reg, top_ok_reg, mid_ok_reg;
    logic emit_reg;
    logic signed [11:0] gx_reg [0:2];
    logic signed [11:0] gy_reg [0:2];
    logic [20:0] n_reg [0:2];
    logic [7:0] root_reg [0:2];
    logic [2:0] bit_reg;
    logic root_done_reg;
    logic fe_reg;
    logic out_v_reg;
    sem_out_t out_reg;
    logic [ROW_W:0] in_row_p1;
    logic real_n, emit_n;
    logic col_wrap;

    always_comb begin
        if (width_cfg_reg == '0) w_eff = (COL_W+1)'(1);
        else if (width_cfg_reg > 11'(MAX_WIDTH)) w_eff = (COL_W+1)'(MAX_WIDTH);
        else w_eff = (COL_W+1)'(width_cfg_reg);
        if (height_cfg_reg == '0) h_eff = (ROW_W+1)'(1);
        else if (height_cfg_reg > 13'(HEIGHT_LIMIT)) h_eff = (ROW_W+1)'(HEIGHT_LIMIT);
        else h_eff = (ROW_W+1)'(height_cfg_reg);
    end

    assign real_n = in_row_reg < h_eff;
    assign stat.skip = real_n && req_reg.command == CMD_FLUSH;
    assign in_row_p1 = in_row_reg + 1'b1;
    assign emit_n = (in_row_reg >= 2) || (in_row_reg == 1 && in_col_reg >= 1);
    assign stat.emit = emit_reg;
    assign stat.root_done = root_done_reg;
    assign col_wrap = ({1'b0, in_col_reg} + 1'b1) >= w_eff;

    // line store: one read slot for top, one for mid, written at top slot
    always_ff @(posedge aclk) begin
        if (cmd.read) begin
            top_q <= ram[{in_row_reg[0], in_col_reg}];
            mid_q <= ram[{~in_row_reg[0], in_col_reg}];
            if (real_n && !stat.skip)
                ram[{in_row_reg[0], in_col_reg}] <=
                    {req_reg.in_red, req_reg.in_green, req_reg.in_blue};
        end
    end

    // position flags taken before the counters advance
    always_ff @(posedge aclk) begin
        if (cmd.load) req_reg <= s_data;
        if (cmd.read) begin
            real_reg <= real_n;
            emit_reg <= emit_n;
            top_ok_reg <= in_row_reg >= 2 && (in_row_reg - 2) < h_eff;
            mid_ok_reg <= in_row_reg >= 1 && (in_row_reg - 1) < h_eff;
        end
    end

    // position counters and window
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_cfg_reg <= 11'd640;
            height_cfg_reg <= 13'd480;
            in_col_reg <= '0;
            in_row_reg <= '0;
            out_col_reg <= '0;
            out_row_reg <= '0;
            for (int r = 0; r < 3; r++)
                for (int c = 0; c < 3; c++) win_reg[r][c] <= '0;
        end else if (cfg_we) begin
            if (cfg_index == REG_WIDTH) width_cfg_reg <= cfg_data[10:0];
            else height_cfg_reg <= cfg_data;
            in_col_reg <= '0;
            in_row_reg <= '0;
            out_col_reg <= '0;
            out_row_reg <= '0;
            for (int r = 0; r < 3; r++)
                for (int c = 0; c < 3; c++) win_reg[r][c] <= '0;
        end else begin
            if (cmd.read && !stat.skip) begin
                if (col_wrap) begin
                    in_col_reg <= '0;
                    in_row_reg <= in_row_p1;
                end else begin
                    in_col_reg <= in_col_reg + 1'b1;
                end
            end
            if (cmd.shift) begin
                for (int r = 0; r < 3; r++) begin
                    win_reg[r][0] <= win_reg[r][1];
                    win_reg[r][1] <= win_reg[r][2];
                end
                win_reg[0][2] <= top_ok_reg ? top_q : 24'd0;
                win_reg[1][2] <= mid_ok_reg ? mid_q : 24'd0;
                win_reg[2][2] <= real_reg ?
                    {req_reg.in_red, req_reg.in_green, req_reg.in_blue} : 24'd0;
                if (emit_reg) begin
                    fe_reg <= ({1'b0, out_row_reg} + 1'b1 >= h_eff) &&
                              ({1'b0, out_col_reg} + 1'b1 >= w_eff);
                end
            end
            if (cmd.publish) begin
                if (fe_reg) begin
                    in_col_reg <= '0;
                    in_row_reg <= '0;
                    out_col_reg <= '0;
                    out_row_reg <= '0;
                    for (int r = 0; r < 3; r++)
                        for (int c = 0; c < 3; c++) win_reg[r][c] <= '0;
                end else if ({1'b0, out_col_reg} + 1'b1 >= w_eff) begin
                    out_col_reg <= '0;
                    out_row_reg <= out_row_reg + 1'b1;
                end else begin
                    out_col_reg <= out_col_reg + 1'b1;
                end
            end
        end
    end

    // gradients with border masking
    logic rv [0:2];
    logic cv [0:2];
    always_comb begin
        for (int d = 0; d < 3; d++) begin
            rv[d] = !((d == 0 && out_row_reg == '0) ||
                      (d == 2 && ({1'b0, out_row_reg} + 1'b1) >= h_eff));
            cv[d] = !((d == 0 && out_col_reg == '0) ||
                      (d == 2 && ({1'b0, out_col_reg} + 1'b1) >= w_eff));
        end
    end

    always_ff @(posedge aclk) begin
        logic signed [11:0] p [0:2][0:2];
        if (cmd.grad) begin
            for (int ch = 0; ch < 3; ch++) begin
                for (int r = 0; r < 3; r++)
                    for (int c = 0; c < 3; c++)
                        p[r][c] = (rv[r] && cv[c]) ?
                            $signed({4'd0, win_reg[r][c][8*(2-ch) +: 8]}) : 12'sd0;
                gx_reg[ch] <= 12'((p[0][2] - p[0][0]) + 2*(p[1][2] - p[1][0])
                              + (p[2][2] - p[2][0]));
                gy_reg[ch] <= 12'((p[2][0] - p[0][0]) + 2*(p[2][1] - p[0][1])
                              + (p[2][2] - p[0][2]));
            end
        end
    end

    // sum of squares reaches 21 bits before saturation
    always_ff @(posedge aclk) begin
        if (cmd.square)
            for (int ch = 0; ch < 3; ch++)
                n_reg[ch] <= 21'($unsigned(22'(gx_reg[ch]) * 22'(gx_reg[ch])) +
                                 $unsigned(22'(gy_reg[ch]) * 22'(gy_reg[ch])));
    end

    // bit-at-a-time square root, eight steps then rounding
    always_ff @(posedge aclk) begin
        logic [7:0] t;
        if (!aresetn) begin
            root_done_reg <= 1'b0;
            bit_reg <= '0;
        end else if (cmd.root_start) begin
            root_done_reg <= 1'b0;
            bit_reg <= 3'd7;
            for (int ch = 0; ch < 3; ch++) root_reg[ch] <= '0;
        end else if (cmd.root_step && !root_done_reg) begin
            for (int ch = 0; ch < 3; ch++) begin
                t = root_reg[ch] | (8'd1 << bit_reg);
                if (16'(t) * 16'(t) <= n_reg[ch]) root_reg[ch] <= t;
            end
            if (bit_reg == '0) root_done_reg <= 1'b1;
            bit_reg <= bit_reg - 1'b1;
        end
    end

    function automatic logic [7:0] round_sat(input logic [7:0] r, input logic [20:0] n);
        logic [19:0] lim;
        lim = 20'(r) * 20'(r) + 20'(r);
        if (n > 21'(SAT_BOUND)) return 8'd255;
        if (n > 21'(lim)) return r + 1'b1;
        return r;
    endfunction

    always_ff @(posedge aclk) begin
        if (!aresetn) out_v_reg <= 1'b0;
        else if (cmd.publish) begin
            out_v_reg <= 1'b1;
            out_reg.out_red <= round_sat(root_reg[0], n_reg[0]);
            out_reg.out_green <= round_sat(root_reg[1], n_reg[1]);
            out_reg.out_blue <= round_sat(root_reg[2], n_reg[2]);
            out_reg.frame_end <= fe_reg;
        end else if (m_ready) out_v_reg <= 1'b0;
    end

    assign out_busy = out_v_reg && !m_ready;
    assign m_valid = out_v_reg;
    assign m_data = out_reg;

`include "sobel_edge_magnitude_rgb_macros.svh"
    `SEM_ASSERT_NEXT(a_pub_valid, cmd.publish, m_valid, "published result not shown")
    `SEM_ASSERT_IMP(a_pub_done, cmd.publish, root_done_reg, "publish before root done")
    `SEM_ASSERT_NEXT(a_hold, m_valid && !m_ready && !cmd.publish, $stable(m_data), "result changed")
endmodule

### rtl/sobel_edge_magnitude_rgb.sv
// Sobel edge magnitude per RGB channel over a raster stream, 3x3 window, black border.
// Each request is handled alone: a request that gives a result passes through read,
// window shift, gradient, square, eight root steps, a wait to see the root finish,
// and output before the next request is taken; one that gives none returns to idle
// after the window shift, and a flush dropped during a frame returns after the read.
// The square root is serial, one bit per step, then rounded. A result still waiting
// at the output holds the controller until it is taken. Config writes restart the frame;
// the user must make them while idle, which the block does not enforce.
module sobel_edge_magnitude_rgb (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  sem_pkg::sem_in_t                s_data,
    output logic                            m_valid,
    input  logic                            m_ready,
    output sem_pkg::sem_out_t               m_data,
    input  logic                            cfg_we,
    input  logic [sem_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [sem_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import sem_pkg::*;

    sem_cmd_t  cmd;
    sem_stat_t stat;
    logic      out_busy;

    sem_ctrl u_ctrl (
        .aclk(aclk), .aresetn(aresetn), .s_valid(s_valid), .s_ready(s_ready),
        .out_busy(out_busy), .stat(stat), .cmd(cmd)
    );

    sem_datapath u_dp (
        .aclk(aclk), .aresetn(aresetn), .s_data(s_data), .cfg_we(cfg_we),
        .cfg_index(cfg_index), .cfg_data(cfg_data), .cmd(cmd), .stat(stat),
        .out_busy(out_busy), .m_ready(m_ready), .m_valid(m_valid), .m_data(m_data)
    );
endmodule

### test/tb_top.sv
// self-checking testbench for the sobel edge magnitude block with an RGB raster predictor
import sem_pkg::*;

class frame_sb;
    logic [10:0] width_reg;
    logic [12:0] height_reg;
    logic [23:0] rows[2*MAX_WIDTH];
    logic [23:0] win[3][3];
    int unsigned in_col, in_row, out_col, out_row;
    sem_out_t pending[$];
    int unsigned fails;

    function new();
        width_reg = 11'd640;
        height_reg = 13'd480;
        fails = 0;
        restart();
    endfunction

    function int unsigned eff_w();
        if (width_reg == 0) return 1;
        if (width_reg > MAX_WIDTH) return MAX_WIDTH;
        return width_reg;
    endfunction

    function int unsigned eff_h();
        if (height_reg == 0) return 1;
        if (height_reg > HEIGHT_LIMIT) return HEIGHT_LIMIT;
        return height_reg;
    endfunction

    function void restart();
        for (int r = 0; r < 3; r++)
            for (int c = 0; c < 3; c++)
                win[r][c] = '0;
        in_col = 0;
        in_row = 0;
        out_col = 0;
        out_row = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        if (idx == REG_WIDTH) width_reg = val[10:0];
        else height_reg = val;
        restart();
    endfunction

    function bit frame_filled();
        return in_row >= eff_h();
    endfunction

    // true when a flush request would be dropped without any effect
    function bit ignores(sem_in_t d);
        return !frame_filled() && d.command == CMD_FLUSH;
    endfunction

    function logic [7:0] round_root(int unsigned n);
        int unsigned r;
        int unsigned t;
        if (n > 65280) return 8'd255;
        r = 0;
        for (int b = 7; b >= 0; b--) begin
            t = r | (1 << b);
            if (t * t <= n) r = t;
        end
        if (n > r * r + r) r++;
        return (r > 255) ? 8'd255 : r[7:0];
    endfunction

    function logic [7:0] channel_edge(int sh, int unsigned w, int unsigned h);
        int gx, gy, rr, cc, v;
        int kx[3][3];
        int ky[3][3];
        kx = '{'{-1, 0, 1}, '{-2, 0, 2}, '{-1, 0, 1}};
        ky = '{'{-1, -2, -1}, '{0, 0, 0}, '{1, 2, 1}};
        gx = 0;
        gy = 0;
        for (int dr = 0; dr < 3; dr++) begin
            rr = int'(out_row) - 1 + dr;
            if (rr < 0 || rr >= int'(h)) continue;
            for (int dc = 0; dc < 3; dc++) begin
                cc = int'(out_col) - 1 + dc;
                if (cc < 0 || cc >= int'(w)) continue;
                v = (win[dr][dc] >> sh) & 8'hff;
                gx += kx[dr][dc] * v;
                gy += ky[dr][dc] * v;
            end
        end
        return round_root(gx * gx + gy * gy);
    endfunction

    function void note_request(sem_in_t d);
        int unsigned w, h, ir, ic;
        logic [23:0] pix, top, mid, bot;
        bit live;
        sem_out_t res;
        w = eff_w();
        h = eff_h();
        ir = in_row;
        ic = in_col;
        live = ir < h;
        if (live && d.command == CMD_FLUSH) return;
        pix = {d.in_red, d.in_green, d.in_blue};
        top = '0;
        mid = '0;
        bot = '0;
        if (ir >= 2 && ir - 2 < h) top = rows[(ir & 1) * MAX_WIDTH + ic];
        if (ir >= 1 && ir - 1 < h) mid = rows[((ir + 1) & 1) * MAX_WIDTH + ic];
        if (live) begin
            bot = pix;
            rows[(ir & 1) * MAX_WIDTH + ic] = pix;
        end
        for (int r = 0; r < 3; r++) begin
            win[r][0] = win[r][1];
            win[r][1] = win[r][2];
        end
        win[0][2] = top;
        win[1][2] = mid;
        win[2][2] = bot;
        in_col = ic + 1;
        if (in_col >= w) begin
            in_col = 0;
            in_row = ir + 1;
        end
        if (!(ir >= 2 || (ir == 1 && ic >= 1))) return;
        res.out_red = channel_edge(16, w, h);
        res.out_green = channel_edge(8, w, h);
        res.out_blue = channel_edge(0, w, h);
        res.frame_end = 1'b0;
        if (out_row + 1 >= h && out_col + 1 >= w) begin
            res.frame_end = 1'b1;
            restart();
        end else begin
            out_col++;
            if (out_col >= w) begin
                out_col = 0;
                out_row++;
            end
        end
        pending.push_back(res);
    endfunction

    function void check(sem_out_t got);
        sem_out_t exp;
        if (pending.size() == 0) begin
            if (fails < 10) $display("unexpected result %h", got);
            fails++;
            return;
        end
        exp = pending.pop_front();
        if (got.out_red != exp.out_red || got.out_green != exp.out_green ||
            got.out_blue != exp.out_blue || got.frame_end != exp.frame_end) begin
            if (fails < 10)
                $display("mismatch: exp r=%0d g=%0d b=%0d end=%0d, got r=%0d g=%0d b=%0d end=%0d",
                         exp.out_red, exp.out_green, exp.out_blue, exp.frame_end,
                         got.out_red, got.out_green, got.out_blue, got.frame_end);
            fails++;
        end
    endfunction
endclass

module tb_top;
    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    sem_in_t s_data = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    sem_out_t m_data;
    logic cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = REG_WIDTH;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    frame_sb sb = new();
    int unsigned burst_left = 0;
    int unsigned sent = 0;
    int unsigned quiet = 0;
    int unsigned ready_mode = 0;
    int unsigned ready_cnt = 0;

    sobel_edge_magnitude_rgb uut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // receiver stall pattern: always ready, random, or long stalls
    always @(posedge aclk) begin
        ready_cnt <= ready_cnt + 1;
        if (ready_cnt % 97 == 0) ready_mode <= $urandom_range(0, 2);
        case (ready_mode)
            0: m_ready <= 1'b1;
            1: m_ready <= 1'($urandom_range(0, 1));
            default: m_ready <= ($urandom_range(0, 7) == 0);
        endcase
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) sb.check(m_data);
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) quiet <= 0;
        else quiet <= quiet + 1;
        if (quiet > 5000) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    function automatic logic [7:0] pick_chan();
        case ($urandom_range(0, 4))
            0: return 8'd0;
            1: return 8'd255;
            default: return 8'($urandom);
        endcase
    endfunction

    task automatic send_request(sem_in_t d);
        if (burst_left == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge aclk);
            burst_left = ($urandom_range(0, 3) == 0) ? 200 : $urandom_range(1, 30);
        end
        s_valid <= 1'b1;
        s_data <= d;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        if (!sb.ignores(d)) sent++;
        sb.note_request(d);
        burst_left--;
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        burst_left = 0;
        while (sb.pending.size() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
    endtask

    task automatic set_frame(logic [CFG_DATA_W-1:0] w, logic [CFG_DATA_W-1:0] h);
        drain();
        cfg_we <= 1'b1;
        cfg_index <= REG_WIDTH;
        cfg_data <= w;
        @(posedge aclk);
        cfg_index <= REG_HEIGHT;
        cfg_data <= h;
        @(posedge aclk);
        cfg_we <= 1'b0;
        @(posedge aclk);
        sb.write_reg(REG_WIDTH, w);
        sb.write_reg(REG_HEIGHT, h);
    endtask

    // pattern 0: random, 1: yellow and blue in turn, 2: full yellow
    task automatic stream(int n, int pattern);
        sem_in_t d;
        for (int i = 0; i < n; i++) begin
            d.in_red = pick_chan();
            d.in_green = pick_chan();
            d.in_blue = pick_chan();
            if (pattern != 0) begin
                d.in_red = (pattern == 2 || i % 2 == 0) ? 8'd255 : 8'd0;
                d.in_green = d.in_red;
                d.in_blue = ~d.in_red;
            end
            if (!sb.frame_filled()) d.command = ($urandom_range(0, 24) == 0) ? CMD_FLUSH : CMD_PIXEL;
            else d.command = ($urandom_range(0, 9) == 0) ? CMD_PIXEL : CMD_FLUSH;
            send_request(d);
        end
    endtask

    initial begin
        int unsigned w, h;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: edges at saturation, zero register values, single rows
        set_frame(13'd3, 13'd3);
        stream(14, 1);
        set_frame(13'd2, 13'd2);
        stream(6, 2);
        set_frame(13'd0, 13'd0);
        stream(3, 0);

        // extreme register values, frames cut short by the next write
        set_frame(13'h1fff, 13'd2);
        stream(1040, 0);
        set_frame(13'd3, 13'h1fff);
        stream(40, 0);
        set_frame(13'd5, 13'd1);
        stream(12, 0);

        while (sent < 1700) begin
            w = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 64) : $urandom_range(1, 12);
            h = $urandom_range(1, 6);
            set_frame(13'(w), 13'(h));
            stream(w * h + w + 2 + $urandom_range(0, w * h), 0);
            if ($urandom_range(0, 3) == 0) drain();
            stream($urandom_range(0, 20), 0);
        end

        drain();
        if (sb.fails == 0 && sb.pending.size() == 0) $display("Regression PASS");
        else $display("Regression FAIL");
        $finish;
    end
endmodule
